@@ rtl/dual_supply_power_sequencer_unit_assert.svh @@
// Assertion macros for the dual-supply power sequencer unit.
// Included by the top level; depends on nothing else.
`ifndef DUAL_SUPPLY_POWER_SEQUENCER_UNIT_ASSERT_SVH
`define DUAL_SUPPLY_POWER_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define DSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DSPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DSPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/dsps_pkg.sv @@
// Shared types and constants of the dual-supply power sequencer.
// No dependencies; used by dsps_cfg, dsps_ctrl and the top level.
package dsps_pkg;

    // configuration register width and index width
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_CHECK_PG    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_WATCH_EDGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_REG_TO_LDO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_LDO_SETTLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_MONITOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_BLIND       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_LDO_OFF     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_REG_OFF     = 3'd7;

    // reset values of the tick registers
    localparam logic [CFG_W-1:0] RST_REG_TO_LDO = 17'd40000;
    localparam logic [CFG_W-1:0] RST_LDO_SETTLE = 17'd5000;
    localparam logic [CFG_W-1:0] RST_MONITOR    = 17'd10000;
    localparam logic [CFG_W-1:0] RST_BLIND      = 17'd35000;
    localparam logic [CFG_W-1:0] RST_LDO_OFF    = 17'd10000;
    localparam logic [CFG_W-1:0] RST_REG_OFF    = 17'd10000;

    // request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_ENABLE  = 2'd1;
    localparam logic [1:0] REQ_DISABLE = 2'd2;

    typedef struct packed {
        logic             check_pg;
        logic             watch_edge;
        logic [CFG_W-1:0] reg_to_ldo;
        logic [CFG_W-1:0] ldo_settle;
        logic [CFG_W-1:0] monitor;
        logic [CFG_W-1:0] blind;
        logic [CFG_W-1:0] ldo_off;
        logic [CFG_W-1:0] reg_off;
    } t_cfg;

    typedef struct packed {
        logic start_failed;
        logic start_done;
        logic edge_watch_armed;
        logic busy_res;
        logic power_ok;
        logic ldo_enable;
        logic regulator_enable;
    } t_result;

endpackage

@@ rtl/dsps_cfg.sv @@
// Configuration register file of the power sequencer.
// Depends on dsps_pkg for the register indexes, reset values and t_cfg.
module dsps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsps_pkg::CFG_W-1:0]     i_cfg_data,
    output dsps_pkg::t_cfg                 o_cfg
);

    dsps_pkg::t_cfg r_cfg;

    // register writes, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_pg   <= 1'b1;
            r_cfg.watch_edge <= 1'b1;
            r_cfg.reg_to_ldo <= dsps_pkg::RST_REG_TO_LDO;
            r_cfg.ldo_settle <= dsps_pkg::RST_LDO_SETTLE;
            r_cfg.monitor    <= dsps_pkg::RST_MONITOR;
            r_cfg.blind      <= dsps_pkg::RST_BLIND;
            r_cfg.ldo_off    <= dsps_pkg::RST_LDO_OFF;
            r_cfg.reg_off    <= dsps_pkg::RST_REG_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dsps_pkg::IDX_CHECK_PG:   r_cfg.check_pg   <= i_cfg_data[0];
                dsps_pkg::IDX_WATCH_EDGE: r_cfg.watch_edge <= i_cfg_data[0];
                dsps_pkg::IDX_REG_TO_LDO: r_cfg.reg_to_ldo <= i_cfg_data;
                dsps_pkg::IDX_LDO_SETTLE: r_cfg.ldo_settle <= i_cfg_data;
                dsps_pkg::IDX_MONITOR:    r_cfg.monitor    <= i_cfg_data;
                dsps_pkg::IDX_BLIND:      r_cfg.blind      <= i_cfg_data;
                dsps_pkg::IDX_LDO_OFF:    r_cfg.ldo_off    <= i_cfg_data;
                dsps_pkg::IDX_REG_OFF:    r_cfg.reg_off    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/dsps_ctrl.sv @@
// Sequencing state machine: applies one tick word to the phase, wait counter
// and drive state. Depends on dsps_pkg for t_cfg, t_result and request codes.
module dsps_ctrl #(
    parameter int COUNT_BITS = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [1:0]        i_req,
    input  logic              i_pg,
    input  dsps_pkg::t_cfg    i_cfg,
    output dsps_pkg::t_result o_res
);

    localparam int CmpW = (COUNT_BITS > dsps_pkg::CFG_W) ? COUNT_BITS : dsps_pkg::CFG_W;
    localparam logic [COUNT_BITS-1:0] CntMax = '1;
    localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REG_WAIT,
        PH_LDO_WAIT,
        PH_MONITOR,
        PH_BLIND,
        PH_DOWN_LDO,
        PH_DOWN_REG
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_last_pg;
    logic                  r_up, n_up;
    logic                  r_armed, n_armed;
    logic                  r_reg, n_reg;
    logic                  r_ldo, n_ldo;
    logic                  n_done, n_failed;

    logic [COUNT_BITS-1:0]       w_cnt_inc;
    logic [dsps_pkg::CFG_W-1:0]  w_wait;
    logic                        w_wait_done;
    logic                        w_fall;

    // saturating tick counter and the wait length of the current phase
    assign w_cnt_inc = (r_cnt == CntMax) ? r_cnt : r_cnt + CntOne;

    always_comb begin
        case (r_phase)
            PH_REG_WAIT: w_wait = i_cfg.reg_to_ldo;
            PH_LDO_WAIT: w_wait = i_cfg.ldo_settle;
            PH_MONITOR:  w_wait = i_cfg.monitor;
            PH_BLIND:    w_wait = i_cfg.blind;
            PH_DOWN_LDO: w_wait = i_cfg.ldo_off;
            PH_DOWN_REG: w_wait = i_cfg.reg_off;
            default:     w_wait = i_cfg.reg_off;
        endcase
    end

    // a wait longer than the counter range ends when the counter saturates
    assign w_wait_done = (CmpW'(w_cnt_inc) >= CmpW'(w_wait)) || (w_cnt_inc == CntMax);

    assign w_fall = r_armed && r_last_pg && !i_pg;

    // next state for one tick
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_up     = r_up;
        n_armed  = r_armed;
        n_reg    = r_reg;
        n_ldo    = r_ldo;
        n_done   = 1'b0;
        n_failed = 1'b0;

        if (w_fall) begin
            n_armed = 1'b0;
            n_up    = 1'b0;
            n_ldo   = 1'b0;
            n_phase = PH_DOWN_LDO;
            n_cnt   = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req == dsps_pkg::REQ_ENABLE) begin
                        n_reg   = 1'b1;
                        n_phase = PH_REG_WAIT;
                        n_cnt   = '0;
                    end else if (i_req == dsps_pkg::REQ_DISABLE) begin
                        n_armed = 1'b0;
                        n_up    = 1'b0;
                        n_ldo   = 1'b0;
                        n_phase = PH_DOWN_LDO;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_cnt = w_cnt_inc;
                    if (w_wait_done) begin
                        n_cnt = '0;
                        unique case (r_phase)
                            PH_REG_WAIT: begin
                                n_ldo   = 1'b1;
                                n_phase = PH_LDO_WAIT;
                            end
                            PH_LDO_WAIT: begin
                                if (!i_cfg.check_pg) begin
                                    n_phase = PH_BLIND;
                                end else if (i_pg) begin
                                    // power-good already high: fail, shut down
                                    n_done   = 1'b1;
                                    n_failed = 1'b1;
                                    n_armed  = 1'b0;
                                    n_up     = 1'b0;
                                    n_ldo    = 1'b0;
                                    n_phase  = PH_DOWN_LDO;
                                end else begin
                                    n_phase = PH_MONITOR;
                                end
                            end
                            PH_MONITOR: begin
                                n_done = 1'b1;
                                if (i_pg) begin
                                    n_up    = 1'b1;
                                    n_armed = i_cfg.watch_edge;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_failed = 1'b1;
                                    n_armed  = 1'b0;
                                    n_up     = 1'b0;
                                    n_ldo    = 1'b0;
                                    n_phase  = PH_DOWN_LDO;
                                end
                            end
                            PH_BLIND: begin
                                n_done  = 1'b1;
                                n_up    = 1'b1;
                                n_phase = PH_IDLE;
                            end
                            PH_DOWN_LDO: begin
                                n_reg   = 1'b0;
                                n_phase = PH_DOWN_REG;
                            end
                            PH_DOWN_REG: begin
                                n_phase = PH_IDLE;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // state update, one tick per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_last_pg <= 1'b0;
            r_up      <= 1'b0;
            r_armed   <= 1'b0;
            r_reg     <= 1'b0;
            r_ldo     <= 1'b0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_last_pg <= i_pg;
            r_up      <= n_up;
            r_armed   <= n_armed;
            r_reg     <= n_reg;
            r_ldo     <= n_ldo;
        end
    end

    // result word reflects the state after this tick
    always_comb begin
        o_res.regulator_enable = n_reg;
        o_res.ldo_enable       = n_ldo;
        o_res.power_ok         = n_up;
        o_res.busy_res         = (n_phase != PH_IDLE);
        o_res.edge_watch_armed = n_armed;
        o_res.start_done       = n_done;
        o_res.start_failed     = n_failed;
    end

endmodule

@@ rtl/dual_supply_power_sequencer_unit.sv @@
// Top level of the dual-supply power sequencer: stream ports, input and
// result registers. Depends on dsps_pkg, dsps_cfg, dsps_ctrl and the assert header.
`include "dual_supply_power_sequencer_unit_assert.svh"

// Each input word is one 10 us tick with a request code and the sampled
// power-good level; each tick returns exactly one status word. The unit takes
// one word per clock cycle while the master side does not stall. A status
// word is presented once its tick has been captured in the input register and
// then passed the sequencing state machine into the result register. A stalled
// master side holds one word in each register and then drops s_axis_tready.
// Wait counters saturate at COUNT_BITS bits. There is no clearing pass after
// reset; configuration registers may be written while no tick is in flight and
// take effect on the next tick.
module dual_supply_power_sequencer_unit #(
    parameter int COUNT_BITS = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // req_type[1:0], power_good_level[2]
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // regulator_enable[0], ldo_enable[1], power_ok[2], busy_res[3],
    // edge_watch_armed[4], start_done[5], start_failed[6]
    output logic [7:0]                     m_axis_tdata,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsps_pkg::CFG_W-1:0]     i_cfg_data
);

    dsps_pkg::t_cfg    w_cfg;
    dsps_pkg::t_result w_res;
    dsps_pkg::t_result r_out;

    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic       r_in_pg;
    logic       r_out_valid;
    logic       w_adv;

    dsps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    dsps_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (r_in_req),
        .i_pg    (r_in_pg),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // tick moves on when the result register is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_out_valid <= w_adv || (r_out_valid && !m_axis_tready);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req <= s_axis_tdata[1:0];
            r_in_pg  <= s_axis_tdata[2];
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.start_failed, r_out.start_done,
                            r_out.edge_watch_armed, r_out.busy_res, r_out.power_ok,
                            r_out.ldo_enable, r_out.regulator_enable};

    // checks
    `DSPS_ASSERT_IMP(a_fail_has_done, i_clk, i_rst_n, r_out_valid && r_out.start_failed, r_out.start_done, "failure pulse without verdict pulse")
    `DSPS_ASSERT_IMP(a_ldo_needs_reg, i_clk, i_rst_n, r_out_valid && r_out.ldo_enable, r_out.regulator_enable, "LDO driven without regulator")
    `DSPS_ASSERT_IMP(a_armed_needs_up, i_clk, i_rst_n, r_out_valid && r_out.edge_watch_armed, r_out.power_ok, "edge watch armed while supplies down")
    `DSPS_ASSERT_NXT(a_in_held_on_stall, i_clk, i_rst_n, r_in_valid && r_out_valid && !m_axis_tready, r_in_valid, "pending tick dropped during output stall")

endmodule
